// ===== hw/rtl/vcc_pkg.sv =====
`timescale 1ns / 1ps

package vcc_pkg;

   localparam int PRODUCT_SLOTS = 12;
   localparam int PROD_IDX_W    = (PRODUCT_SLOTS > 1) ? $clog2(PRODUCT_SLOTS) : 1;
   localparam int NUM_COINS     = 8;
   localparam int COIN_IDX_W    = 3;

   typedef enum logic [1:0] {
      KIND_LOAD_PROD = 2'd0,
      KIND_LOAD_COIN = 2'd1,
      KIND_SELECT    = 2'd2,
      KIND_INSERT    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_LOADED       = 3'd0,
      STAT_AWAIT        = 3'd1,
      STAT_OUT_OF_STOCK = 3'd2,
      STAT_CHANGE       = 3'd3,
      STAT_VENDED       = 3'd4,
      STAT_NO_CHANGE    = 3'd5,
      STAT_IGNORED      = 3'd6
   } status_type;

   typedef struct packed {
      logic [11:0] price;
      logic [7:0]  stock;
   } prod_entry_type;

   // Face value in cents of each denomination, largest first.
   function automatic logic [7:0] coin_value(input logic [COIN_IDX_W-1:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'd200;
         3'd1: val = 8'd100;
         3'd2: val = 8'd50;
         3'd3: val = 8'd20;
         3'd4: val = 8'd10;
         3'd5: val = 8'd5;
         3'd6: val = 8'd2;
         3'd7: val = 8'd1;
      endcase
      return val;
   endfunction

   // ceil(2^16 / value). For any 8-bit amount x, (x * recip) >> 16 is the exact
   // quotient x / value, since the rounding error stays below 1 / value.
   function automatic logic [16:0] coin_recip(input logic [COIN_IDX_W-1:0] idx);
      logic [16:0] val;
      unique case (idx)
         3'd0: val = 17'd328;
         3'd1: val = 17'd656;
         3'd2: val = 17'd1311;
         3'd3: val = 17'd3277;
         3'd4: val = 17'd6554;
         3'd5: val = 17'd13108;
         3'd6: val = 17'd32768;
         3'd7: val = 17'd65536;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/vending_change_controller.sv =====
`timescale 1ns / 1ps

// Vending controller in integer cents. The product table (price and stock) and the
// coin stock table sit in two synchronous memories with a registered read port;
// each entry has a valid bit cleared by reset, so the tables read as zero right
// after reset and no clearing pass is needed. One word is worked on at a time.
// Load words, words that are ignored and a coin that leaves an amount still due
// are handled in the idle state. A selection reads the product, then decides. A
// coin or selection that closes a sale runs the change unit: for each
// denomination a coin memory read, then take and subtract, then a check step.
// When exact change cannot be paid the sale ends there. Else a payout pass visits
// each of the eight denominations, then the product stock is read and written
// back. Steps that emit a result wait while the result side stalls. Results
// leave through an output register, and the next word is taken no earlier than
// the edge at which the last result of the previous word leaves it.
module vending_change_controller (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_item_index,
   input  logic [11:0] req_price_cents,
   input  logic [7:0]  req_count,
   input  logic [3:0]  req_coin_code,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_product_index,
   output logic [11:0] rsp_amount_cents,
   output logic [2:0]  rsp_change_coin,
   output logic [7:0]  rsp_change_count,
   output logic        rsp_last
);

   localparam int PW = vcc_pkg::PROD_IDX_W;
   localparam int CW = vcc_pkg::COIN_IDX_W;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_SEL       = 8'b0000_0010,
      S_COIN_RD   = 8'b0000_0100,
      S_COIN_TAKE = 8'b0000_1000,
      S_CHECK     = 8'b0001_0000,
      S_GIVE      = 8'b0010_0000,
      S_PROD_RD   = 8'b0100_0000,
      S_PROD_WR   = 8'b1000_0000
   } state_type;

   // Memories and their valid bits.
   vcc_pkg::prod_entry_type prod_mem [vcc_pkg::PRODUCT_SLOTS];
   logic [7:0]              coin_mem [vcc_pkg::NUM_COINS];
   logic [vcc_pkg::PRODUCT_SLOTS-1:0] prod_vld_ff;
   logic [vcc_pkg::NUM_COINS-1:0]     coin_vld_ff;

   vcc_pkg::prod_entry_type prod_rdata_ff;
   logic                    prod_rvld_ff;
   logic [7:0]              coin_rdata_ff;
   logic                    coin_rvld_ff;

   logic                    prod_we, prod_re;
   logic [PW-1:0]           prod_waddr, prod_raddr;
   vcc_pkg::prod_entry_type prod_wdata;
   logic                    coin_we, coin_re;
   logic [CW-1:0]           coin_waddr, coin_raddr;
   logic [7:0]              coin_wdata;

   // Control state.
   state_type         state_ff, state_in;
   logic              sale_pending_ff, sale_pending_in;
   logic [3:0]        pending_ff, pending_in;
   logic signed [12:0] amount_due_ff, amount_due_in;
   logic [3:0]        idx_ff, idx_in;
   logic [CW-1:0]     coin_idx_ff, coin_idx_in;
   logic [7:0]        change_ff, change_in;
   logic [7:0]        left_ff, left_in;
   logic [7:0]        quot_ff, quot_in;
   logic [7:0]        take_ff [vcc_pkg::NUM_COINS];
   logic [7:0]        take_in [vcc_pkg::NUM_COINS];
   logic [7:0]        keep_ff [vcc_pkg::NUM_COINS];
   logic [7:0]        keep_in [vcc_pkg::NUM_COINS];

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   vcc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [3:0]          rsp_product_ff, rsp_product_in;
   logic [11:0]         rsp_amount_ff, rsp_amount_in;
   logic [2:0]          rsp_coin_ff, rsp_coin_in;
   logic [7:0]          rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                emit;

   logic               rsp_free;
   logic               req_accept;
   logic               prod_idx_ok;
   logic [11:0]        due_shown;
   logic signed [12:0] new_amount;
   logic [12:0]        neg_amount;
   logic [11:0]        rd_price;
   logic [7:0]         rd_stock;
   logic [7:0]         coin_stock;
   logic [7:0]         take_val;
   logic [15:0]        take_cents;
   logic [24:0]        quot_prod;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = !((state_ff == S_IDLE) && rsp_free);
   assign req_accept  = req_valid && !req_stall;
   assign prod_idx_ok = {1'b0, req_item_index} < 5'(vcc_pkg::PRODUCT_SLOTS);
   assign due_shown   = (amount_due_ff[12] || amount_due_ff == 13'sd0)
                        ? 12'd0 : amount_due_ff[11:0];
   assign new_amount  = amount_due_ff
                        - $signed({5'd0, vcc_pkg::coin_value(req_coin_code[CW-1:0])});
   assign neg_amount  = 13'(-new_amount);

   assign rd_price   = prod_rvld_ff ? prod_rdata_ff.price : 12'd0;
   assign rd_stock   = prod_rvld_ff ? prod_rdata_ff.stock : 8'd0;
   assign coin_stock = coin_rvld_ff ? coin_rdata_ff : 8'd0;
   assign take_val   = (quot_ff < coin_stock) ? quot_ff : coin_stock;
   assign take_cents = 16'(take_val) * 16'(vcc_pkg::coin_value(coin_idx_ff));
   assign quot_prod  = 25'(left_ff) * 25'(vcc_pkg::coin_recip(coin_idx_ff));

   always_comb begin
      state_in        = state_ff;
      sale_pending_in = sale_pending_ff;
      pending_in      = pending_ff;
      amount_due_in   = amount_due_ff;
      idx_in          = idx_ff;
      coin_idx_in     = coin_idx_ff;
      change_in       = change_ff;
      left_in         = left_ff;
      quot_in         = quot_ff;
      take_in         = take_ff;
      keep_in         = keep_ff;

      prod_we    = 1'b0;
      prod_re    = 1'b0;
      prod_waddr = pending_ff[PW-1:0];
      prod_raddr = pending_ff[PW-1:0];
      prod_wdata = prod_rdata_ff;
      coin_we    = 1'b0;
      coin_re    = 1'b0;
      coin_waddr = coin_idx_ff;
      coin_raddr = coin_idx_ff;
      coin_wdata = keep_ff[coin_idx_ff];

      emit           = 1'b0;
      rsp_status_in  = vcc_pkg::STAT_IGNORED;
      rsp_product_in = 4'd0;
      rsp_amount_in  = 12'd0;
      rsp_coin_in    = 3'd0;
      rsp_count_in   = 8'd0;
      rsp_last_in    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (vcc_pkg::kind_type'(req_kind))
                  vcc_pkg::KIND_LOAD_PROD: begin
                     emit           = 1'b1;
                     rsp_product_in = req_item_index;
                     if (prod_idx_ok) begin
                        prod_we          = 1'b1;
                        prod_waddr       = req_item_index[PW-1:0];
                        prod_wdata.price = req_price_cents;
                        prod_wdata.stock = req_count;
                        rsp_status_in    = vcc_pkg::STAT_LOADED;
                        rsp_amount_in    = req_price_cents;
                     end
                  end
                  vcc_pkg::KIND_LOAD_COIN: begin
                     emit = 1'b1;
                     if (!req_item_index[3]) begin
                        coin_we       = 1'b1;
                        coin_waddr    = req_item_index[CW-1:0];
                        coin_wdata    = req_count;
                        rsp_status_in = vcc_pkg::STAT_LOADED;
                     end else begin
                        rsp_product_in = req_item_index;
                     end
                  end
                  vcc_pkg::KIND_SELECT: begin
                     if (sale_pending_ff) begin
                        emit           = 1'b1;
                        rsp_product_in = pending_ff;
                        rsp_amount_in  = due_shown;
                     end else if (!prod_idx_ok) begin
                        emit           = 1'b1;
                        rsp_product_in = req_item_index;
                     end else begin
                        prod_re    = 1'b1;
                        prod_raddr = req_item_index[PW-1:0];
                        idx_in     = req_item_index;
                        state_in   = S_SEL;
                     end
                  end
                  default: begin
                     if (!sale_pending_ff) begin
                        emit = 1'b1;
                     end else if (req_coin_code[3]) begin
                        // Unrecognized coin: the sale goes on unchanged.
                        emit           = 1'b1;
                        rsp_product_in = pending_ff;
                        rsp_amount_in  = due_shown;
                     end else begin
                        amount_due_in = new_amount;
                        if (new_amount[12] || new_amount == 13'sd0) begin
                           change_in   = neg_amount[7:0];
                           left_in     = neg_amount[7:0];
                           coin_idx_in = '0;
                           state_in    = S_COIN_RD;
                        end else begin
                           emit           = 1'b1;
                           rsp_status_in  = vcc_pkg::STAT_AWAIT;
                           rsp_product_in = pending_ff;
                           rsp_amount_in  = new_amount[11:0];
                        end
                     end
                  end
               endcase
            end
         end

         S_SEL: begin
            if (rd_stock == 8'd0) begin
               if (rsp_free) begin
                  emit           = 1'b1;
                  rsp_status_in  = vcc_pkg::STAT_OUT_OF_STOCK;
                  rsp_product_in = idx_ff;
                  state_in       = S_IDLE;
               end
            end else if (rd_price == 12'd0) begin
               // A free product settles at once with no change due.
               sale_pending_in = 1'b1;
               pending_in      = idx_ff;
               amount_due_in   = 13'sd0;
               change_in       = 8'd0;
               left_in         = 8'd0;
               coin_idx_in     = '0;
               state_in        = S_COIN_RD;
            end else if (rsp_free) begin
               sale_pending_in = 1'b1;
               pending_in      = idx_ff;
               amount_due_in   = $signed({1'b0, rd_price});
               emit            = 1'b1;
               rsp_status_in   = vcc_pkg::STAT_AWAIT;
               rsp_product_in  = idx_ff;
               rsp_amount_in   = rd_price;
               state_in        = S_IDLE;
            end
         end

         S_COIN_RD: begin
            coin_re  = 1'b1;
            quot_in  = quot_prod[23:16];
            state_in = S_COIN_TAKE;
         end

         S_COIN_TAKE: begin
            left_in              = left_ff - take_cents[7:0];
            take_in[coin_idx_ff] = take_val;
            keep_in[coin_idx_ff] = coin_stock - take_val;
            if (coin_idx_ff == CW'(vcc_pkg::NUM_COINS - 1)) begin
               coin_idx_in = '0;
               state_in    = S_CHECK;
            end else begin
               coin_idx_in = coin_idx_ff + CW'(1);
               state_in    = S_COIN_RD;
            end
         end

         S_CHECK: begin
            if (left_ff != 8'd0) begin
               // Exact change is not possible: end the sale, stocks untouched.
               if (rsp_free) begin
                  emit            = 1'b1;
                  rsp_status_in   = vcc_pkg::STAT_NO_CHANGE;
                  rsp_product_in  = pending_ff;
                  rsp_amount_in   = {4'd0, change_ff};
                  sale_pending_in = 1'b0;
                  amount_due_in   = 13'sd0;
                  state_in        = S_IDLE;
               end
            end else begin
               state_in = S_GIVE;
            end
         end

         S_GIVE: begin
            if (take_ff[coin_idx_ff] == 8'd0 || rsp_free) begin
               if (take_ff[coin_idx_ff] != 8'd0) begin
                  coin_we        = 1'b1;
                  emit           = 1'b1;
                  rsp_status_in  = vcc_pkg::STAT_CHANGE;
                  rsp_product_in = pending_ff;
                  rsp_coin_in    = coin_idx_ff;
                  rsp_count_in   = take_ff[coin_idx_ff];
                  rsp_last_in    = 1'b0;
               end
               if (coin_idx_ff == CW'(vcc_pkg::NUM_COINS - 1)) begin
                  state_in = S_PROD_RD;
               end else begin
                  coin_idx_in = coin_idx_ff + CW'(1);
               end
            end
         end

         S_PROD_RD: begin
            prod_re  = 1'b1;
            state_in = S_PROD_WR;
         end

         S_PROD_WR: begin
            if (rsp_free) begin
               prod_we          = 1'b1;
               prod_wdata.price = rd_price;
               prod_wdata.stock = (rd_stock != 8'd0) ? rd_stock - 8'd1 : 8'd0;
               emit             = 1'b1;
               rsp_status_in    = vcc_pkg::STAT_VENDED;
               rsp_product_in   = pending_ff;
               rsp_amount_in    = {4'd0, change_ff};
               sale_pending_in  = 1'b0;
               amount_due_in    = 13'sd0;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   // Memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (prod_we) begin
         prod_mem[prod_waddr] <= prod_wdata;
      end
      if (prod_re) begin
         prod_rdata_ff <= prod_mem[prod_raddr];
      end
      if (coin_we) begin
         coin_mem[coin_waddr] <= coin_wdata;
      end
      if (coin_re) begin
         coin_rdata_ff <= coin_mem[coin_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= '0;
         coin_vld_ff  <= '0;
         prod_rvld_ff <= 1'b0;
         coin_rvld_ff <= 1'b0;
      end else begin
         if (prod_we) begin
            prod_vld_ff[prod_waddr] <= 1'b1;
         end
         if (prod_re) begin
            prod_rvld_ff <= prod_vld_ff[prod_raddr];
         end
         if (coin_we) begin
            coin_vld_ff[coin_waddr] <= 1'b1;
         end
         if (coin_re) begin
            coin_rvld_ff <= coin_vld_ff[coin_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         sale_pending_ff <= 1'b0;
         pending_ff      <= 4'd0;
         amount_due_ff   <= 13'sd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sale_pending_ff <= sale_pending_in;
         pending_ff      <= pending_in;
         amount_due_ff   <= amount_due_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      coin_idx_ff <= coin_idx_in;
      change_ff   <= change_in;
      left_ff     <= left_in;
      quot_ff     <= quot_in;
      take_ff     <= take_in;
      keep_ff     <= keep_in;
      if (emit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_product_ff <= rsp_product_in;
         rsp_amount_ff  <= rsp_amount_in;
         rsp_coin_ff    <= rsp_coin_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_product_index = rsp_product_ff;
   assign rsp_amount_cents  = rsp_amount_ff;
   assign rsp_change_coin   = rsp_coin_ff;
   assign rsp_change_count  = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

   a_pending_due_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && sale_pending_ff) |-> (!amount_due_ff[12] && amount_due_ff != 13'sd0))
      else $error("open sale with nothing due while idle");

   a_last_word_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("final word of an item shown while work is still under way");

   a_change_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == vcc_pkg::STAT_CHANGE) |-> !rsp_last_ff)
      else $error("change coin word marked as final");

   a_give_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GIVE) |-> (left_ff == 8'd0 && sale_pending_ff))
      else $error("paying out change that does not add up");

endmodule
